### sv/ising_pkg.sv
// Shared types and constants of the Ising site update core.
`timescale 1ns / 1ps

package ising_pkg;

    localparam int OP_W      = 2;
    localparam int COORD_W   = 10;
    localparam int DRAW_W    = 16;
    localparam int SLOT_W    = 4;
    localparam int THR_W     = 17;
    localparam int J_W       = 16;
    localparam int DIFF_W    = 18;
    localparam int PROD_W    = J_W + DIFF_W;
    localparam int DE_W      = 40;
    localparam int EN_W      = 48;
    localparam int MAG_W     = 22;
    localparam int CNT_W     = 32;
    localparam int NUM_SLOTS = 10;

    typedef enum logic [OP_W-1:0] {
        OP_UPDATE     = 2'd0,
        OP_WRITE_SPIN = 2'd1,
        OP_WRITE_THR  = 2'd2,
        OP_LOAD       = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CALC,
        S_DONE
    } t_state;

    // register select is bit 2 of the byte address
    localparam logic REG_COUPLING = 1'b0;
    localparam logic REG_FIELD    = 1'b1;

endpackage

### sv/ising_metropolis_site_update_core.sv
// Metropolis single-site update engine for a 2D periodic Ising lattice.
`timescale 1ns / 1ps
//
// Usage
//   Request channel (i_in_valid / o_in_stall) carries an opcode and its fields:
//   update site, write spin, write threshold slot, load totals. Result channel
//   (o_out_valid / i_out_stall) returns one result per request, in order.
//   User writes coupling and field term over APB port while idle; unenforced.
// Sequence
//   The lattice lives in one row-wide memory (one row per word) with two read
//   ports and registered reads. Update and write-spin requests on the lattice
//   go through these steps: accept (reads up and center rows), neighbor read
//   (down row), multiply, commit. Threshold, load and out-of-lattice requests
//   go straight from accept to commit. The result register loads at commit.
// Reset
//   After reset a clearing pass sets every spin to +1, one row per cycle, with
//   o_in_stall high; APB writes are taken meanwhile.
// Backpressure
//   A new request is taken while a result waits; commit holds until the result
//   register is free, so nothing is lost or repeated under i_out_stall.

module ising_metropolis_site_update_core #(
    parameter int LATTICE_SIDE = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,

    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic        [ising_pkg::OP_W-1:0]      i_opcode,
    input  logic        [ising_pkg::COORD_W-1:0]   i_row_index,
    input  logic        [ising_pkg::COORD_W-1:0]   i_col_index,
    input  logic        [ising_pkg::DRAW_W-1:0]    i_random_draw,
    input  logic                                   i_spin_value,
    input  logic        [ising_pkg::SLOT_W-1:0]    i_table_index,
    input  logic        [ising_pkg::THR_W-1:0]     i_threshold_value,
    input  logic signed [ising_pkg::EN_W-1:0]      i_energy_load,
    input  logic signed [ising_pkg::MAG_W-1:0]     i_magnetisation_load,

    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic                                   o_accepted,
    output logic                                   o_bad_site,
    output logic                                   o_site_spin,
    output logic signed [ising_pkg::DE_W-1:0]      o_energy_change,
    output logic signed [ising_pkg::EN_W-1:0]      o_running_energy,
    output logic signed [ising_pkg::MAG_W-1:0]     o_running_magnetisation,
    output logic        [ising_pkg::CNT_W-1:0]     o_steps_done,
    output logic        [ising_pkg::CNT_W-1:0]     o_flips_done,

    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic        [2:0]                      paddr,
    input  logic        [31:0]                     pwdata,
    output logic        [31:0]                     prdata,
    output logic                                   pready
);
    import ising_pkg::*;

    localparam int AW = $clog2(LATTICE_SIDE);
    localparam logic [AW-1:0] LAST = AW'(LATTICE_SIDE - 1);
    localparam logic [AW-1:0] ONE_A = AW'(1);
    localparam logic [COORD_W:0] SIDE_V = (COORD_W + 1)'(LATTICE_SIDE);
    localparam logic signed [EN_W-1:0] EN_MAX = {1'b0, {(EN_W - 1){1'b1}}};
    localparam logic signed [EN_W-1:0] EN_MIN = {1'b1, {(EN_W - 1){1'b0}}};

    // configuration
    logic signed [J_W-1:0] r_coupling;
    logic signed [J_W-1:0] r_field;

    // state machine
    t_state r_state, n_state;
    logic [AW-1:0] r_clr;

    // spin memory: one word per lattice row
    logic [LATTICE_SIDE-1:0] r_spin_mem [LATTICE_SIDE];
    logic [LATTICE_SIDE-1:0] r_rd_a, r_rd_b;
    logic                    c_mem_we;
    logic [AW-1:0]           c_waddr, c_raddr_a, c_raddr_b;
    logic [LATTICE_SIDE-1:0] c_wdata;

    // threshold table and totals
    logic [THR_W-1:0]        r_thr [NUM_SLOTS];
    logic signed [EN_W-1:0]  r_energy, n_energy;
    logic [MAG_W-1:0]        r_magnet, n_magnet;
    logic [CNT_W-1:0]        r_steps, n_steps;
    logic [CNT_W-1:0]        r_flips, n_flips;

    // captured request
    t_opcode                 r_op;
    logic [AW-1:0]           r_row, r_col;
    logic [DRAW_W-1:0]       r_draw;
    logic                    r_spin_in;
    logic [SLOT_W-1:0]       r_tidx;
    logic [THR_W-1:0]        r_tval;
    logic signed [EN_W-1:0]  r_eload;
    logic [MAG_W-1:0]        r_mload;
    logic                    r_upd, r_wspin, r_bad;

    // neighbor and compute stage
    logic                    r_up_bit;
    logic [LATTICE_SIDE-1:0] r_center;
    logic                    r_s;
    logic [SLOT_W-1:0]       r_slot;
    logic signed [DE_W-1:0]  r_de;

    // result register
    logic                    r_out_valid;
    logic                    r_out_acc, r_out_bad, r_out_spin;
    logic signed [DE_W-1:0]  r_out_de;

    // combinational
    logic                    c_accept, c_out_free, c_commit;
    logic                    c_site_ok;
    logic [AW-1:0]           c_in_row, c_up_row, c_dn_row, c_lf, c_rt;
    logic                    c_s, c_dn_bit, c_lf_bit, c_rt_bit;
    logic [2:0]              c_cnt;
    logic signed [DIFF_W-1:0] c_diff, c_sdiff;
    logic signed [PROD_W-1:0] c_prod;
    logic signed [DE_W-1:0]  c_de;
    logic [SLOT_W-1:0]       c_slot;
    logic                    c_acc, c_new_spin, c_out_spin;
    logic signed [EN_W:0]    c_sum;
    logic signed [EN_W-1:0]  c_sat;
    logic [LATTICE_SIDE-1:0] c_wrow;

    // ---------------- APB ----------------
    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[2])
            REG_COUPLING: prdata = {16'd0, r_coupling};
            REG_FIELD:    prdata = {16'd0, r_field};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coupling <= J_W'(256);
            r_field    <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_COUPLING: r_coupling <= pwdata[J_W-1:0];
                REG_FIELD:    r_field    <= pwdata[J_W-1:0];
                default:      ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign c_accept   = (r_state == S_IDLE) && i_in_valid;
    assign c_out_free = !r_out_valid || !i_out_stall;
    assign c_commit   = (r_state == S_DONE) && c_out_free;

    assign c_site_ok = ({1'b0, i_row_index} < SIDE_V) && ({1'b0, i_col_index} < SIDE_V);
    assign c_in_row  = i_row_index[AW-1:0];
    assign c_up_row  = (c_in_row == '0) ? LAST : c_in_row - ONE_A;
    assign c_dn_row  = (r_row == LAST) ? '0 : r_row + ONE_A;
    assign c_lf      = (r_col == '0) ? LAST : r_col - ONE_A;
    assign c_rt      = (r_col == LAST) ? '0 : r_col + ONE_A;

    // ---------------- state machine ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + ONE_A;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == LAST) n_state = S_IDLE;
            S_IDLE: begin
                if (i_in_valid) begin
                    if (c_site_ok && (i_opcode == OP_UPDATE || i_opcode == OP_WRITE_SPIN))
                        n_state = S_READ;
                    else
                        n_state = S_DONE;
                end
            end
            S_READ:  n_state = S_CALC;
            S_CALC:  n_state = S_DONE;
            S_DONE:  if (c_out_free) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        c_raddr_a  = r_row;
        c_raddr_b  = r_row;
        c_mem_we   = 1'b0;
        c_waddr    = r_row;
        c_wdata    = c_wrow;
        unique case (r_state)
            S_CLEAR: begin
                c_mem_we = 1'b1;
                c_waddr  = r_clr;
                c_wdata  = '1;
            end
            S_IDLE: begin
                c_raddr_a = c_up_row;
                c_raddr_b = c_in_row;
            end
            S_READ: c_raddr_a = c_dn_row;
            S_CALC: ;
            S_DONE: c_mem_we = c_commit && (r_wspin || (r_upd && c_acc));
            default: ;
        endcase
    end

    // ---------------- spin memory ----------------
    always_ff @(posedge i_clk) begin
        if (c_mem_we) begin
            r_spin_mem[c_waddr] <= c_wdata;
        end
        r_rd_a <= r_spin_mem[c_raddr_a];
        r_rd_b <= r_spin_mem[c_raddr_b];
    end

    // ---------------- request capture ----------------
    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_op      <= t_opcode'(i_opcode);
            r_row     <= c_in_row;
            r_col     <= i_col_index[AW-1:0];
            r_draw    <= i_random_draw;
            r_spin_in <= i_spin_value;
            r_tidx    <= i_table_index;
            r_tval    <= i_threshold_value;
            r_eload   <= i_energy_load;
            r_mload   <= i_magnetisation_load;
            r_upd     <= c_site_ok && (i_opcode == OP_UPDATE);
            r_wspin   <= c_site_ok && (i_opcode == OP_WRITE_SPIN);
            r_bad     <= !c_site_ok && (i_opcode == OP_UPDATE || i_opcode == OP_WRITE_SPIN);
        end
        if (r_state == S_READ) begin
            r_up_bit <= r_rd_a[r_col];
            r_center <= r_rd_b;
        end
        if (r_state == S_CALC) begin
            r_s    <= c_s;
            r_slot <= c_slot;
            r_de   <= c_de;
        end
    end

    // ---------------- energy change ----------------
    assign c_s      = r_center[r_col];
    assign c_dn_bit = r_rd_a[r_col];
    assign c_lf_bit = r_center[c_lf];
    assign c_rt_bit = r_center[c_rt];
    assign c_cnt    = 3'(r_up_bit) + 3'(c_dn_bit) + 3'(c_lf_bit) + 3'(c_rt_bit);

    // neighbor sum * 256 = count * 512 - 1024
    assign c_diff  = $signed(DIFF_W'({c_cnt, 9'd0})) - DIFF_W'(1024) - DIFF_W'(r_field);
    assign c_sdiff = c_s ? c_diff : -c_diff;
    assign c_prod  = c_sdiff * r_coupling;
    assign c_de    = DE_W'(c_prod) <<< 1;
    assign c_slot  = c_s ? SLOT_W'(5) + SLOT_W'(c_cnt) : SLOT_W'(c_cnt);

    // ---------------- decision and totals ----------------
    assign c_acc      = r_upd && (r_de[DE_W-1] || (r_thr[r_slot] > THR_W'(r_draw)));
    assign c_new_spin = r_wspin ? r_spin_in : !r_s;
    assign c_sum      = (EN_W + 1)'(r_energy) + (EN_W + 1)'(r_de);

    always_comb begin
        if (c_sum[EN_W] != c_sum[EN_W-1])
            c_sat = c_sum[EN_W] ? EN_MIN : EN_MAX;
        else
            c_sat = c_sum[EN_W-1:0];
    end

    always_comb begin
        c_wrow        = r_center;
        c_wrow[r_col] = c_new_spin;
    end

    always_comb begin
        c_out_spin = 1'b0;
        if (r_wspin)
            c_out_spin = r_spin_in;
        else if (r_upd)
            c_out_spin = c_acc ? !r_s : r_s;
    end

    always_comb begin
        n_energy = r_energy;
        n_magnet = r_magnet;
        n_steps  = r_steps;
        n_flips  = r_flips;
        if (r_op == OP_LOAD) begin
            n_energy = r_eload;
            n_magnet = r_mload;
            n_steps  = '0;
            n_flips  = '0;
        end else if (r_upd) begin
            n_steps = r_steps + CNT_W'(1);
            if (c_acc) begin
                n_flips  = r_flips + CNT_W'(1);
                n_energy = c_sat;
                // +1 flipping down raises the down-minus-up count
                n_magnet = r_s ? r_magnet + MAG_W'(2) : r_magnet - MAG_W'(2);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy <= '0;
            r_magnet <= '0;
            r_steps  <= '0;
            r_flips  <= '0;
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_thr[k] <= '0;
            end
        end else if (c_commit) begin
            r_energy <= n_energy;
            r_magnet <= n_magnet;
            r_steps  <= n_steps;
            r_flips  <= n_flips;
            if (r_op == OP_WRITE_THR && r_tidx < SLOT_W'(NUM_SLOTS)) begin
                r_thr[r_tidx] <= r_tval;
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_commit) begin
            r_out_acc  <= c_acc;
            r_out_bad  <= r_bad;
            r_out_spin <= c_out_spin;
            r_out_de   <= r_upd ? r_de : '0;
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_accepted              = r_out_acc;
    assign o_bad_site              = r_out_bad;
    assign o_site_spin             = r_out_spin;
    assign o_energy_change         = r_out_de;
    assign o_running_energy        = r_energy;
    assign o_running_magnetisation = r_magnet;
    assign o_steps_done            = r_steps;
    assign o_flips_done            = r_flips;

endmodule

### sv/ising_chk.sv
// Port-level checks on the result channel of the Ising site update core.
`timescale 1ns / 1ps

module ising_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic                                o_accepted,
    input logic                                o_bad_site,
    input logic                                o_site_spin,
    input logic signed [ising_pkg::DE_W-1:0]   o_energy_change,
    input logic signed [ising_pkg::EN_W-1:0]   o_running_energy
);
    import ising_pkg::*;

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_energy_change)
            && $stable(o_running_energy) && $stable(o_accepted))
        else $error("stalled result changed");

    a_acc_ok_site: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_accepted && o_bad_site))
        else $error("flip accepted on a bad site");

    a_bad_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_site |-> !o_site_spin && (o_energy_change == '0))
        else $error("bad site result carries data");

    a_neg_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_bad_site && o_energy_change[DE_W-1] |-> o_accepted)
        else $error("negative energy change not accepted");

endmodule

bind ising_metropolis_site_update_core ising_chk u_ising_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_accepted       (o_accepted),
    .o_bad_site       (o_bad_site),
    .o_site_spin      (o_site_spin),
    .o_energy_change  (o_energy_change),
    .o_running_energy (o_running_energy)
);

### tb/ising_metropolis_site_update_core_tb.sv
// Self-checking testbench for the Ising Metropolis site update core.
`timescale 1ns / 1ps

module ising_metropolis_site_update_core_tb;
    import ising_pkg::*;

    localparam int SIDE           = 64;
    localparam int SITES          = SIDE * SIDE;
    localparam int DIR_ROWS       = 19;
    localparam int RAND_PER_PHASE = 358;
    localparam int PHASES         = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam longint EN_MAX     = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint EN_MIN     = -EN_MAX - 64'sd1;
    localparam logic [2:0] ADDR_COUPLING = {REG_COUPLING, 2'b00};
    localparam logic [2:0] ADDR_FIELD    = {REG_FIELD, 2'b00};

    typedef struct packed {
        t_opcode                   op;
        logic [COORD_W-1:0]        row;
        logic [COORD_W-1:0]        col;
        logic [DRAW_W-1:0]         draw;
        logic                      spin;
        logic [SLOT_W-1:0]         slot;
        logic [THR_W-1:0]          thr;
        logic signed [EN_W-1:0]    energy;
        logic signed [MAG_W-1:0]   magnet;
    } t_site_req;

    typedef struct packed {
        logic                      accepted;
        logic                      bad_site;
        logic                      site_spin;
        logic signed [DE_W-1:0]    energy_change;
        logic signed [EN_W-1:0]    running_energy;
        logic signed [MAG_W-1:0]   running_magnetisation;
        logic [CNT_W-1:0]          steps_done;
        logic [CNT_W-1:0]          flips_done;
    } t_site_res;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic [OP_W-1:0]            i_opcode;
    logic [COORD_W-1:0]         i_row_index;
    logic [COORD_W-1:0]         i_col_index;
    logic [DRAW_W-1:0]          i_random_draw;
    logic                       i_spin_value;
    logic [SLOT_W-1:0]          i_table_index;
    logic [THR_W-1:0]           i_threshold_value;
    logic signed [EN_W-1:0]     i_energy_load;
    logic signed [MAG_W-1:0]    i_magnetisation_load;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic                       o_accepted;
    logic                       o_bad_site;
    logic                       o_site_spin;
    logic signed [DE_W-1:0]     o_energy_change;
    logic signed [EN_W-1:0]     o_running_energy;
    logic signed [MAG_W-1:0]    o_running_magnetisation;
    logic [CNT_W-1:0]           o_steps_done;
    logic [CNT_W-1:0]           o_flips_done;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [2:0]                 paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;

    // lattice model and totals
    bit                         lattice [SITES];
    logic [THR_W-1:0]           thr_table [NUM_SLOTS];
    longint                     energy_sum;
    logic [MAG_W-1:0]           magnet_sum;
    logic [CNT_W-1:0]           step_count;
    logic [CNT_W-1:0]           flip_count;
    logic signed [J_W-1:0]      coupling_q;
    logic signed [J_W-1:0]      field_q;

    t_site_res                  due_results [$];
    int                         mismatch_count;
    int                         sender_idle_pct;
    int                         recv_stall_pct;

    t_site_req                  dir_req [DIR_ROWS];
    t_site_res                  dir_res [DIR_ROWS];
    bit                         dir_typed [DIR_ROWS];

    ising_metropolis_site_update_core #(
        .LATTICE_SIDE(SIDE)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_opcode(i_opcode),
        .i_row_index(i_row_index),
        .i_col_index(i_col_index),
        .i_random_draw(i_random_draw),
        .i_spin_value(i_spin_value),
        .i_table_index(i_table_index),
        .i_threshold_value(i_threshold_value),
        .i_energy_load(i_energy_load),
        .i_magnetisation_load(i_magnetisation_load),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_accepted(o_accepted),
        .o_bad_site(o_bad_site),
        .o_site_spin(o_site_spin),
        .o_energy_change(o_energy_change),
        .o_running_energy(o_running_energy),
        .o_running_magnetisation(o_running_magnetisation),
        .o_steps_done(o_steps_done),
        .o_flips_done(o_flips_done),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(64'd20_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic t_site_req mk_req(input t_opcode op, input int row, input int col,
                                         input int draw, input int spin_v, input int slot,
                                         input int thr, input longint energy, input int mag);
        t_site_req r;
        r.op     = op;
        r.row    = COORD_W'(row);
        r.col    = COORD_W'(col);
        r.draw   = DRAW_W'(draw);
        r.spin   = spin_v[0];
        r.slot   = SLOT_W'(slot);
        r.thr    = THR_W'(thr);
        r.energy = EN_W'(energy);
        r.magnet = MAG_W'(mag);
        return r;
    endfunction

    function automatic t_site_res mk_res(input int acc, input int bad, input int spin_v,
                                         input longint de, input longint energy,
                                         input int mag, input int steps, input int flips);
        t_site_res r;
        r.accepted              = acc[0];
        r.bad_site              = bad[0];
        r.site_spin             = spin_v[0];
        r.energy_change         = DE_W'(de);
        r.running_energy        = EN_W'(energy);
        r.running_magnetisation = MAG_W'(mag);
        r.steps_done            = CNT_W'(steps);
        r.flips_done            = CNT_W'(flips);
        return r;
    endfunction

    function automatic int site_sign(input int row, input int col);
        return lattice[row * SIDE + col] ? 1 : -1;
    endfunction

    // Advance the lattice model by one request and return the result it produces.
    function automatic t_site_res metropolis_step(input t_site_req r);
        t_site_res res;
        int row, col, up, dn, lf, rt, s, nsum, slot;
        longint diff, de, sum;
        res = '0;
        de  = 0;
        row = int'(r.row);
        col = int'(r.col);
        case (r.op) inside
            OP_UPDATE, OP_WRITE_SPIN: begin
                if (row >= SIDE || col >= SIDE) begin
                    res.bad_site = 1'b1;
                end else if (r.op == OP_WRITE_SPIN) begin
                    lattice[row * SIDE + col] = r.spin;
                    res.site_spin = r.spin;
                end else begin
                    up   = (row == 0) ? SIDE - 1 : row - 1;
                    dn   = (row == SIDE - 1) ? 0 : row + 1;
                    lf   = (col == 0) ? SIDE - 1 : col - 1;
                    rt   = (col == SIDE - 1) ? 0 : col + 1;
                    s    = site_sign(row, col);
                    nsum = site_sign(up, col) + site_sign(dn, col) +
                           site_sign(row, lf) + site_sign(row, rt);
                    diff = longint'(nsum) * 256 - longint'(field_q);
                    slot = (s > 0 ? 5 : 0) + (nsum + 4) / 2;
                    de   = 2 * longint'(coupling_q) * longint'(s) * diff;
                    step_count = step_count + 1'b1;
                    if (de < 0 || thr_table[slot] > r.draw) begin
                        res.accepted = 1'b1;
                        lattice[row * SIDE + col] = (s < 0);
                        flip_count = flip_count + 1'b1;
                        // down-minus-up count rises when the spin turns to -1
                        magnet_sum = (s > 0) ? magnet_sum + MAG_W'(2) : magnet_sum - MAG_W'(2);
                        sum = energy_sum + de;
                        energy_sum = (sum > EN_MAX) ? EN_MAX : (sum < EN_MIN) ? EN_MIN : sum;
                    end
                    res.site_spin = lattice[row * SIDE + col];
                end
            end
            OP_WRITE_THR: begin
                if (int'(r.slot) < NUM_SLOTS) thr_table[r.slot] = r.thr;
            end
            OP_LOAD: begin
                energy_sum = longint'(r.energy);
                magnet_sum = r.magnet;
                step_count = '0;
                flip_count = '0;
            end
            default: ;
        endcase
        res.energy_change         = de[DE_W-1:0];
        res.running_energy        = energy_sum[EN_W-1:0];
        res.running_magnetisation = magnet_sum;
        res.steps_done            = step_count;
        res.flips_done            = flip_count;
        return res;
    endfunction

    function automatic t_site_req random_request();
        t_site_req r;
        int pick;
        longint en;
        pick = $urandom_range(99);
        if (pick < 60) r.op = OP_UPDATE;
        else if (pick < 75) r.op = OP_WRITE_SPIN;
        else if (pick < 90) r.op = OP_WRITE_THR;
        else r.op = OP_LOAD;
        // mostly sites on the lattice, a few anywhere in the field range
        if ($urandom_range(99) < 90) begin
            r.row = COORD_W'($urandom_range(SIDE - 1));
            r.col = COORD_W'($urandom_range(SIDE - 1));
        end else begin
            r.row = COORD_W'($urandom);
            r.col = COORD_W'($urandom);
        end
        r.draw = DRAW_W'($urandom);
        r.spin = 1'($urandom_range(1));
        r.slot = ($urandom_range(99) < 85) ? SLOT_W'($urandom_range(NUM_SLOTS - 1))
                                           : SLOT_W'($urandom);
        case ($urandom_range(2))
            0: r.thr = THR_W'($urandom);
            1: r.thr = THR_W'(65536);
            default: r.thr = THR_W'($urandom_range(65535));
        endcase
        case ($urandom_range(3))
            0: en = {$urandom, $urandom};
            1: en = EN_MAX - longint'($urandom);
            2: en = EN_MIN + longint'($urandom);
            default: en = longint'($urandom_range(2000000)) - 64'sd1000000;
        endcase
        r.energy = EN_W'(en);
        r.magnet = ($urandom_range(99) < 70) ? MAG_W'($urandom)
                                             : MAG_W'(int'($urandom_range(64)) - 32);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic signed [63:0] got,
                               input logic signed [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [J_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {{(32 - J_W){value[J_W-1]}}, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_COUPLING) coupling_q = value;
        else field_q = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input t_site_req r, input bit use_typed,
                                input t_site_res typed_res);
        t_site_res predicted;
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_opcode             <= r.op;
        i_row_index          <= r.row;
        i_col_index          <= r.col;
        i_random_draw        <= r.draw;
        i_spin_value         <= r.spin;
        i_table_index        <= r.slot;
        i_threshold_value    <= r.thr;
        i_energy_load        <= r.energy;
        i_magnetisation_load <= r.magnet;
        i_in_valid           <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = metropolis_step(r);
        due_results.insert(due_results.size(), use_typed ? typed_res : predicted);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_site_res got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_accepted, o_bad_site, o_site_spin, o_energy_change, o_running_energy,
                   o_running_magnetisation, o_steps_done, o_flips_done};
            if (due_results.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                want = due_results.pop_front();
                check_field("accepted", got.accepted, want.accepted);
                check_field("bad_site", got.bad_site, want.bad_site);
                check_field("site_spin", got.site_spin, want.site_spin);
                check_field("energy_change", got.energy_change, want.energy_change);
                check_field("running_energy", got.running_energy, want.running_energy);
                check_field("running_magnetisation", got.running_magnetisation,
                            want.running_magnetisation);
                check_field("steps_done", got.steps_done, want.steps_done);
                check_field("flips_done", got.flips_done, want.flips_done);
            end
        end
    end

    initial begin
        t_site_res none;
        none = '0;
        i_rst_n              = 1'b0;
        i_in_valid           = 1'b0;
        i_opcode             = '0;
        i_row_index          = '0;
        i_col_index          = '0;
        i_random_draw        = '0;
        i_spin_value         = 1'b0;
        i_table_index        = '0;
        i_threshold_value    = '0;
        i_energy_load        = '0;
        i_magnetisation_load = '0;
        i_out_stall          = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        mismatch_count       = 0;
        sender_idle_pct      = 38;
        recv_stall_pct       = 70;
        for (int i = 0; i < SITES; i++) lattice[i] = 1'b1;
        for (int i = 0; i < NUM_SLOTS; i++) thr_table[i] = '0;
        energy_sum = 0;
        magnet_sum = '0;
        step_count = '0;
        flip_count = '0;
        coupling_q = 16'sd256;
        field_q    = 16'sd0;

        // directed rows run under the reset coupling and field
        dir_req[0]  = mk_req(OP_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0);
        dir_res[0]  = mk_res(0, 0, 1, 524288, 0, 0, 1, 0);
        dir_req[1]  = mk_req(OP_UPDATE, 64, 0, 0, 0, 0, 0, 0, 0);
        dir_res[1]  = mk_res(0, 1, 0, 0, 0, 0, 1, 0);
        dir_req[2]  = mk_req(OP_UPDATE, 0, 1023, 0, 0, 0, 0, 0, 0);
        dir_res[2]  = mk_res(0, 1, 0, 0, 0, 0, 1, 0);
        dir_req[3]  = mk_req(OP_WRITE_SPIN, 1023, 1023, 0, 1, 0, 0, 0, 0);
        dir_res[3]  = mk_res(0, 1, 0, 0, 0, 0, 1, 0);
        dir_req[4]  = mk_req(OP_WRITE_SPIN, 63, 63, 0, 0, 0, 0, 0, 0);
        dir_res[4]  = mk_res(0, 0, 0, 0, 0, 0, 1, 0);
        dir_req[5]  = mk_req(OP_WRITE_THR, 0, 0, 0, 0, 15, 65536, 0, 0);
        dir_res[5]  = mk_res(0, 0, 0, 0, 0, 0, 1, 0);
        dir_req[6]  = mk_req(OP_WRITE_THR, 0, 0, 0, 0, 9, 65536, 0, 0);
        dir_res[6]  = mk_res(0, 0, 0, 0, 0, 0, 1, 0);
        dir_req[7]  = mk_req(OP_UPDATE, 10, 10, 65535, 0, 0, 0, 0, 0);
        dir_res[7]  = mk_res(1, 0, 0, 524288, 524288, 2, 2, 1);
        dir_req[8]  = mk_req(OP_UPDATE, 10, 10, 0, 0, 0, 0, 0, 0);
        dir_req[9]  = mk_req(OP_UPDATE, 0, 63, 0, 0, 0, 0, 0, 0);
        dir_req[10] = mk_req(OP_UPDATE, 63, 0, 0, 0, 0, 0, 0, 0);
        dir_req[11] = mk_req(OP_WRITE_THR, 0, 0, 0, 0, 0, 131071, 0, 0);
        dir_req[12] = mk_req(OP_LOAD, 0, 0, 0, 0, 0, 0, EN_MAX, 1048576);
        dir_res[12] = mk_res(0, 0, 0, 0, EN_MAX, 1048576, 0, 0);
        dir_req[13] = mk_req(OP_UPDATE, 10, 10, 65535, 0, 0, 0, 0, 0);
        dir_req[14] = mk_req(OP_LOAD, 0, 0, 0, 0, 0, 0, EN_MIN, -2097152);
        dir_res[14] = mk_res(0, 0, 0, 0, EN_MIN, -2097152, 0, 0);
        dir_req[15] = mk_req(OP_UPDATE, 10, 10, 65535, 0, 0, 0, 0, 0);
        dir_req[16] = mk_req(OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0);
        dir_res[16] = mk_res(0, 0, 0, 0, 0, 0, 0, 0);
        dir_req[17] = mk_req(OP_WRITE_THR, 0, 0, 0, 0, 4, 0, 0, 0);
        dir_res[17] = mk_res(0, 0, 0, 0, 0, 0, 0, 0);
        dir_req[18] = mk_req(OP_UPDATE, 63, 63, 65535, 0, 0, 0, 0, 0);
        foreach (dir_typed[i])
            dir_typed[i] = (i <= 7 || i == 12 || i == 14 || i == 16 || i == 17);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                1: begin
                    write_register(ADDR_COUPLING, 16'h8000);
                    write_register(ADDR_FIELD, 16'h7FFF);
                    sender_idle_pct = 70;
                    recv_stall_pct  = 38;
                end
                2: begin
                    write_register(ADDR_COUPLING, 16'h7FFF);
                    write_register(ADDR_FIELD, 16'h8000);
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                3: begin
                    write_register(ADDR_COUPLING, J_W'($urandom));
                    write_register(ADDR_FIELD, J_W'(int'($urandom_range(2048)) - 1024));
                end
                default: ;
            endcase
            if (phase == 0) begin
                for (int i = 0; i < DIR_ROWS; i++)
                    send_request(dir_req[i], dir_typed[i], dir_res[i]);
            end
            for (int i = 0; i < RAND_PER_PHASE; i++)
                send_request(random_request(), 1'b0, none);
            // hold off register writes until the block is idle
            drain_results();
        end

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
